// ===== hw/rtl/cwk_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and a helper function of the text console
// no dependencies

package cwk_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int SPACE_COUNT   = 10;

  localparam int CELLS      = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DIGIT_CELL = 40;

  // field widths of the transactions
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int SPC_W  = 4;
  localparam int CELL_W = 16;

  localparam int CELL_AW   = $clog2(CELLS);
  localparam int SAVED_AW  = $clog2(SPACE_COUNT * CELLS);
  localparam int SPC_IDX_W = (SPACE_COUNT > 1) ? $clog2(SPACE_COUNT) : 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0a;
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] ZERO_CHAR      = 8'h30;
  localparam logic [CHAR_W-1:0] DEFAULT_COLOUR = 8'h07;

  localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] ROW_STRIDE = CELL_AW'(SCREEN_WIDTH);
  localparam logic [CELL_AW-1:0] LAST_MOVE  = CELL_AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [ROW_W-1:0]   HOME_ROW   = ROW_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 3'd0,
    OP_COLOUR = 3'd1,
    OP_WRITE  = 3'd2,
    OP_SWITCH = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // cell address request and answer of the address unit
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } agu_req_t;

  typedef struct packed {
    logic [CELL_AW-1:0] addr;
    logic               hit;
  } agu_rsp_t;

  // power-on content of a cell of a given workspace
  function automatic logic [CELL_W-1:0] init_cell(input logic [CELL_AW-1:0] idx,
                                                  input logic [SPC_W-1:0]   space);
    logic [CHAR_W-1:0] ch;
    ch = BLANK_CHAR;
    if (CELLS > DIGIT_CELL && idx == CELL_AW'(DIGIT_CELL)) begin
      ch = ZERO_CHAR + CHAR_W'(space);
    end
    return {DEFAULT_COLOUR, ch};
  endfunction

endpackage

// ===== hw/rtl/cwk_in_if.sv =====
`timescale 1ns / 1ps
// command channel of the text console
// depends on cwk_pkg

interface cwk_in_if;
  logic                          valid;
  logic                          ready;
  logic [cwk_pkg::OP_W-1:0]      opcode;
  logic [cwk_pkg::CHAR_W-1:0]    char_code;
  logic [cwk_pkg::CHAR_W-1:0]    attr;
  logic [cwk_pkg::COL_W-1:0]     pos_x;
  logic [cwk_pkg::ROW_W-1:0]     pos_y;
  logic [cwk_pkg::SPC_W-1:0]     target_space;

  modport source (output valid, output opcode, output char_code, output attr,
                  output pos_x, output pos_y, output target_space, input ready);
  modport sink   (input valid, input opcode, input char_code, input attr,
                  input pos_x, input pos_y, input target_space, output ready);
endinterface

// ===== hw/rtl/cwk_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the text console
// depends on cwk_pkg

interface cwk_out_if;
  logic                        valid;
  logic                        ready;
  logic [cwk_pkg::COL_W-1:0]   cursor_col;
  logic [cwk_pkg::ROW_W-1:0]   cursor_row;
  logic [cwk_pkg::CELL_W-1:0]  cell_value;
  logic [cwk_pkg::SPC_W-1:0]   active_space;
  logic                        switch_taken;

  modport source (output valid, output cursor_col, output cursor_row, output cell_value,
                  output active_space, output switch_taken, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input cell_value,
                  input active_space, input switch_taken, output ready);
endinterface

// ===== hw/rtl/cwk_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module cwk_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/cwk_agu.sv =====
`timescale 1ns / 1ps
// cell address unit: row * width + column and the on-screen check
// depends on cwk_pkg

module cwk_agu (
  input  cwk_pkg::agu_req_t req,
  output cwk_pkg::agu_rsp_t rsp
);

  assign rsp.addr = cwk_pkg::CELL_AW'(req.row) * cwk_pkg::ROW_STRIDE
                  + cwk_pkg::CELL_AW'(req.col);
  assign rsp.hit  = ({1'b0, req.col} < (cwk_pkg::COL_W + 1)'(cwk_pkg::SCREEN_WIDTH))
                 && ({1'b0, req.row} < (cwk_pkg::ROW_W + 1)'(cwk_pkg::SCREEN_HEIGHT));

endmodule

// ===== hw/rtl/text_console_with_workspaces_core.sv =====
`timescale 1ns / 1ps
// text console with workspaces: command sequencer, screen and saved screen rams
// depends on cwk_pkg, cwk_in_if, cwk_out_if, cwk_ram, cwk_agu
//
// usage
//   in_ch carries one command transaction (opcode, char, attr, x, y, target);
//   out_ch returns exactly one result transaction per command with the
//   cursor, the cell read, the active workspace and the switch flag
//   in_ch.ready is high only while the sequencer is idle: one command at a time
// sequence
//   set colour, cell write, put char without scroll: an execute state, then the result
//   cell read: adds a state for the registered screen ram read
//   put char that scrolls: rows move up one cell at a time, a read state then a
//   write state on the single screen ram port pair, then the bottom row is blanked
//   workspace switch: each cell is read and then written in both rams, one cell
//   at a time
// reset
//   after rst_n the screen ram is swept to spaces in colour 07 with the
//   workspace digit, with in_ch.ready low; saved screens are never swept:
//   a workspace not yet saved reads as its power-on content
// stall
//   the result sits in an output register; the next command is taken while
//   it waits, and a finished command holds until out_ch.ready frees the register

module text_console_with_workspaces_core (
  input  logic      clk,
  input  logic      rst_n,
  cwk_in_if.sink    in_ch,
  cwk_out_if.source out_ch
);

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_EXEC   = 10'b0000000100,
    S_RD     = 10'b0000001000,
    S_SCR_RD = 10'b0000010000,
    S_SCR_WR = 10'b0000100000,
    S_BLANK  = 10'b0001000000,
    S_SW_RD  = 10'b0010000000,
    S_SW_WR  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // latched command
  logic [cwk_pkg::OP_W-1:0]   op_r;
  logic [cwk_pkg::CHAR_W-1:0] ch_r;
  logic [cwk_pkg::CHAR_W-1:0] at_r;
  logic [cwk_pkg::COL_W-1:0]  px_r;
  logic [cwk_pkg::ROW_W-1:0]  py_r;
  logic [cwk_pkg::SPC_W-1:0]  tg_r;

  // console state
  logic [cwk_pkg::ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [cwk_pkg::COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [cwk_pkg::CHAR_W-1:0]  colour_r, colour_nxt;
  logic [cwk_pkg::SPC_W-1:0]   shown_r, shown_nxt;
  logic                        taken_r, taken_nxt;
  logic [cwk_pkg::CELL_W-1:0]  cell_r, cell_nxt;
  logic [cwk_pkg::CELL_AW-1:0] idx_r, idx_nxt;

  // per-workspace saved cursor, colour and saved-screen flag
  logic [cwk_pkg::ROW_W-1:0]  saved_row_r    [cwk_pkg::SPACE_COUNT];
  logic [cwk_pkg::COL_W-1:0]  saved_col_r    [cwk_pkg::SPACE_COUNT];
  logic [cwk_pkg::CHAR_W-1:0] saved_colour_r [cwk_pkg::SPACE_COUNT];
  logic [cwk_pkg::SPACE_COUNT-1:0] saved_flag_r;
  logic [cwk_pkg::SAVED_AW-1:0] save_base_r;
  logic [cwk_pkg::SAVED_AW-1:0] load_base_r;
  logic                         load_init_r;

  // output register
  logic                        out_valid_r;
  logic [cwk_pkg::COL_W-1:0]   out_col_r;
  logic [cwk_pkg::ROW_W-1:0]   out_row_r;
  logic [cwk_pkg::CELL_W-1:0]  out_cell_r;
  logic [cwk_pkg::SPC_W-1:0]   out_space_r;
  logic                        out_taken_r;
  logic                        out_load;

  // ram ports
  logic                         scr_we;
  logic [cwk_pkg::CELL_AW-1:0]  scr_waddr, scr_raddr;
  logic [cwk_pkg::CELL_W-1:0]   scr_wdata, scr_rdata;
  logic                         sav_we;
  logic [cwk_pkg::SAVED_AW-1:0] sav_waddr, sav_raddr;
  logic [cwk_pkg::CELL_W-1:0]   sav_rdata;

  cwk_pkg::agu_req_t agu_req;
  cwk_pkg::agu_rsp_t agu_rsp;

  logic [cwk_pkg::COL_W:0]      col_inc;
  logic [cwk_pkg::ROW_W:0]      row_inc;
  logic                         col_wrap, row_bottom, sw_ok, sw_go, accept;
  logic [cwk_pkg::SPC_IDX_W-1:0] tg_idx, shown_idx;

  assign accept    = in_ch.valid && in_ch.ready;
  assign tg_idx    = tg_r[cwk_pkg::SPC_IDX_W-1:0];
  assign shown_idx = shown_r[cwk_pkg::SPC_IDX_W-1:0];

  assign col_inc    = {1'b0, cur_col_r} + 1'b1;
  assign row_inc    = {1'b0, cur_row_r} + 1'b1;
  assign col_wrap   = col_inc >= (cwk_pkg::COL_W + 1)'(cwk_pkg::SCREEN_WIDTH);
  assign row_bottom = row_inc >= (cwk_pkg::ROW_W + 1)'(cwk_pkg::SCREEN_HEIGHT);
  assign sw_ok      = ({1'b0, tg_r} < (cwk_pkg::SPC_W + 1)'(cwk_pkg::SPACE_COUNT))
                   && (tg_r != shown_r);

  // put char addresses the cursor, cell write and read address x,y
  always_comb begin
    if (op_r == cwk_pkg::OP_PUT) begin
      agu_req.row = cur_row_r;
      agu_req.col = cur_col_r;
    end else begin
      agu_req.row = py_r;
      agu_req.col = px_r;
    end
  end

  cwk_agu u_agu (
    .req (agu_req),
    .rsp (agu_rsp)
  );

  cwk_ram #(
    .DEPTH (cwk_pkg::CELLS),
    .WIDTH (cwk_pkg::CELL_W)
  ) u_screen_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  cwk_ram #(
    .DEPTH (cwk_pkg::SPACE_COUNT * cwk_pkg::CELLS),
    .WIDTH (cwk_pkg::CELL_W)
  ) u_saved_ram (
    .clk   (clk),
    .we    (sav_we),
    .waddr (sav_waddr),
    .wdata (scr_rdata),
    .raddr (sav_raddr),
    .rdata (sav_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    colour_nxt  = colour_r;
    shown_nxt   = shown_r;
    taken_nxt   = taken_r;
    cell_nxt    = cell_r;
    scr_we      = 1'b0;
    scr_waddr   = idx_r;
    scr_wdata   = cwk_pkg::init_cell(idx_r, shown_r);
    scr_raddr   = idx_r;
    sav_we      = 1'b0;
    sav_waddr   = save_base_r + cwk_pkg::SAVED_AW'(idx_r);
    sav_raddr   = load_base_r + cwk_pkg::SAVED_AW'(idx_r);
    sw_go       = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      // power-on sweep of the visible screen
      S_CLR: begin
        scr_we = 1'b1;
        if (idx_r == cwk_pkg::LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        taken_nxt = 1'b0;
        cell_nxt  = '0;
        state_nxt = S_DONE;
        case (op_r)
          cwk_pkg::OP_PUT: begin
            if (ch_r != cwk_pkg::NEWLINE_CHAR) begin
              scr_we      = 1'b1;
              scr_waddr   = agu_rsp.addr;
              scr_wdata   = {colour_r, ch_r};
              cur_col_nxt = col_inc[cwk_pkg::COL_W-1:0];
            end
            if (ch_r == cwk_pkg::NEWLINE_CHAR || col_wrap) begin
              cur_col_nxt = '0;
              if (row_bottom) begin
                // scroll rows 2.. up, the status row stays
                cur_row_nxt = cwk_pkg::LAST_ROW;
                idx_nxt     = cwk_pkg::ROW_STRIDE;
                state_nxt   = S_SCR_RD;
              end else begin
                cur_row_nxt = row_inc[cwk_pkg::ROW_W-1:0];
              end
            end
          end
          cwk_pkg::OP_COLOUR: begin
            colour_nxt = at_r;
          end
          cwk_pkg::OP_WRITE: begin
            if (agu_rsp.hit) begin
              scr_we    = 1'b1;
              scr_waddr = agu_rsp.addr;
              scr_wdata = {at_r, ch_r};
            end
          end
          cwk_pkg::OP_SWITCH: begin
            if (sw_ok) begin
              sw_go       = 1'b1;
              taken_nxt   = 1'b1;
              shown_nxt   = tg_r;
              cur_row_nxt = saved_row_r[tg_idx];
              cur_col_nxt = saved_col_r[tg_idx];
              colour_nxt  = saved_colour_r[tg_idx];
              idx_nxt     = '0;
              state_nxt   = S_SW_RD;
            end
          end
          cwk_pkg::OP_READ: begin
            if (agu_rsp.hit) begin
              scr_raddr = agu_rsp.addr;
              state_nxt = S_RD;
            end
          end
          default: ;
        endcase
      end

      S_RD: begin
        cell_nxt  = scr_rdata;
        state_nxt = S_DONE;
      end

      S_SCR_RD: begin
        scr_raddr = idx_r + cwk_pkg::ROW_STRIDE;
        state_nxt = S_SCR_WR;
      end

      S_SCR_WR: begin
        scr_we    = 1'b1;
        scr_wdata = scr_rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (idx_r == cwk_pkg::LAST_MOVE) ? S_BLANK : S_SCR_RD;
      end

      // bottom row takes blanks in the current colour
      S_BLANK: begin
        scr_we    = 1'b1;
        scr_wdata = {colour_r, cwk_pkg::BLANK_CHAR};
        if (idx_r == cwk_pkg::LAST_CELL) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SW_RD: begin
        state_nxt = S_SW_WR;
      end

      // save the old cell and load the target cell in the same slot
      S_SW_WR: begin
        sav_we = 1'b1;
        scr_we = 1'b1;
        if (!load_init_r) begin
          scr_wdata = sav_rdata;
        end
        if (idx_r == cwk_pkg::LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SW_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      idx_r        <= '0;
      cur_row_r    <= cwk_pkg::HOME_ROW;
      cur_col_r    <= '0;
      colour_r     <= cwk_pkg::DEFAULT_COLOUR;
      shown_r      <= '0;
      taken_r      <= 1'b0;
      cell_r       <= '0;
      saved_flag_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < cwk_pkg::SPACE_COUNT; i++) begin
        saved_row_r[i]    <= cwk_pkg::HOME_ROW;
        saved_col_r[i]    <= '0;
        saved_colour_r[i] <= cwk_pkg::DEFAULT_COLOUR;
      end
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      colour_r  <= colour_nxt;
      shown_r   <= shown_nxt;
      taken_r   <= taken_nxt;
      cell_r    <= cell_nxt;
      if (sw_go) begin
        saved_flag_r[shown_idx]   <= 1'b1;
        saved_row_r[shown_idx]    <= cur_row_r;
        saved_col_r[shown_idx]    <= cur_col_r;
        saved_colour_r[shown_idx] <= colour_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_ch.opcode;
      ch_r <= in_ch.char_code;
      at_r <= in_ch.attr;
      px_r <= in_ch.pos_x;
      py_r <= in_ch.pos_y;
      tg_r <= in_ch.target_space;
    end
    if (sw_go) begin
      save_base_r <= cwk_pkg::SAVED_AW'(shown_r) * cwk_pkg::SAVED_AW'(cwk_pkg::CELLS);
      load_base_r <= cwk_pkg::SAVED_AW'(tg_r) * cwk_pkg::SAVED_AW'(cwk_pkg::CELLS);
      load_init_r <= !saved_flag_r[tg_idx];
    end
    if (out_load) begin
      out_col_r   <= cur_col_r;
      out_row_r   <= cur_row_r;
      out_cell_r  <= cell_r;
      out_space_r <= shown_r;
      out_taken_r <= taken_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cursor_col   = out_col_r;
  assign out_ch.cursor_row   = out_row_r;
  assign out_ch.cell_value   = out_cell_r;
  assign out_ch.active_space = out_space_r;
  assign out_ch.switch_taken = out_taken_r;

endmodule

// ===== hw/rtl/cwk_chk.sv =====
`timescale 1ns / 1ps
// port-level checks of the text console and their bind to the top level
// depends on cwk_pkg and text_console_with_workspaces_core

module cwk_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cwk_pkg::COL_W-1:0]   cursor_col,
  input logic [cwk_pkg::ROW_W-1:0]   cursor_row,
  input logic [cwk_pkg::CELL_W-1:0]  cell_value,
  input logic [cwk_pkg::SPC_W-1:0]   active_space,
  input logic                        switch_taken
);

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // cursor never enters the status row and stays on screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cursor_row != '0
      && {1'b0, cursor_row} < (cwk_pkg::ROW_W + 1)'(cwk_pkg::SCREEN_HEIGHT)
      && {1'b0, cursor_col} < (cwk_pkg::COL_W + 1)'(cwk_pkg::SCREEN_WIDTH))
    else $error("cursor off screen");

  // shown workspace exists, a switch reports no cell
  a_space_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, active_space} < (cwk_pkg::SPC_W + 1)'(cwk_pkg::SPACE_COUNT)
      && (!switch_taken || cell_value == '0))
    else $error("bad workspace result");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_col) && $stable(cursor_row)
      && $stable(cell_value) && $stable(active_space) && $stable(switch_taken))
    else $error("result changed under stall");

endmodule

bind text_console_with_workspaces_core cwk_chk u_cwk_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cursor_col   (out_ch.cursor_col),
  .cursor_row   (out_ch.cursor_row),
  .cell_value   (out_ch.cell_value),
  .active_space (out_ch.active_space),
  .switch_taken (out_ch.switch_taken)
);
